// ----- hdl/ocdrw_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ocdrw_pkg
// Shared constants for the OLED command and display RAM writer.
// ----------------------------------------------------------------------------
package ocdrw_pkg;

    localparam int PANEL_COLUMNS = 128;
    localparam int PANEL_ROWS    = 64;

    localparam int COL_W  = 7;
    localparam int PAGE_W = 3;

    localparam logic [COL_W-1:0]  MAX_COL  = COL_W'(PANEL_COLUMNS - 1);
    localparam logic [PAGE_W-1:0] MAX_PAGE = PAGE_W'(PANEL_ROWS / 8 - 1);

    // Display RAM geometry
    localparam int RAM_DEPTH = 1024;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);
    localparam int RAM_DW    = 8;

    // Bus event codes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;

    // Control byte bits
    localparam int CTRL_CONT_BIT = 7;
    localparam int CTRL_DATA_BIT = 6;

    // Command codes
    localparam logic [7:0] CMD_DISPLAY_OFF  = 8'hAE;
    localparam logic [7:0] CMD_DISPLAY_ON   = 8'hAF;
    localparam logic [7:0] CMD_NORMAL       = 8'hA6;
    localparam logic [7:0] CMD_INVERSE      = 8'hA7;
    localparam logic [7:0] CMD_COL_WINDOW   = 8'h21;
    localparam logic [7:0] CMD_PAGE_WINDOW  = 8'h22;
    localparam logic [7:0] CMD_ADDR_MODE    = 8'h20;
    localparam logic [7:0] CMD_CONTRAST     = 8'h81;
    localparam logic [7:0] CMD_MUX_RATIO    = 8'hA8;
    localparam logic [7:0] CMD_DISP_OFFSET  = 8'hD3;
    localparam logic [7:0] CMD_COM_PINS     = 8'hDA;
    localparam logic [7:0] CMD_CLOCK_DIV    = 8'hD5;
    localparam logic [7:0] CMD_PRECHARGE    = 8'hD9;
    localparam logic [7:0] CMD_VCOM_DESEL   = 8'hDB;
    localparam logic [7:0] CMD_CHARGE_PUMP  = 8'h8D;

endpackage
`default_nettype wire

// ----- hdl/ocdrw_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ocdrw_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module ocdrw_ram #(
    parameter int DATA_WIDTH = 8,
    parameter int DEPTH      = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [DATA_WIDTH-1:0]    wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [DATA_WIDTH-1:0]    rd_data
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// ----- hdl/oled_command_and_display_ram_writer_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// oled_command_and_display_ram_writer_top
// Decodes OLED controller bus events (byte write, read, stop) into control,
// command and display data transactions; stores data bytes in display RAM
// with horizontal addressing inside a column/page window.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------
//  s_      | in  | s_valid / s_ready  | s_opcode[1:0], s_data_byte[7:0]
//  m_      | out | m_valid / m_ready  | m_acked, m_ram_written, m_write_column,
//          |     |                    | m_write_page, m_display_enabled,
//          |     |                    | m_display_inverted
//
//  One transaction per cycle while s_ready is high: decode, cursor update
//  and the RAM write all settle in the accept cycle; the result lands in
//  the output register. After reset all 1024 entries of the display RAM
//  are cleared, one entry per cycle; s_ready stays low during that pass.
//  A stalled result holds the output register; s_ready follows m_ready
//  while a result is waiting.
// ----------------------------------------------------------------------------
module oled_command_and_display_ram_writer_top
    import ocdrw_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,

    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_opcode,
    input  wire logic [7:0]        s_data_byte,

    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_acked,
    output logic                   m_ram_written,
    output logic [COL_W-1:0]       m_write_column,
    output logic [PAGE_W-1:0]      m_write_page,
    output logic                   m_display_enabled,
    output logic                   m_display_inverted
);

    // Which parameter byte the next command byte fills
    typedef enum logic [2:0] {
        PEND_NONE,
        PEND_COL_START,
        PEND_COL_END,
        PEND_PAGE_START,
        PEND_PAGE_END,
        PEND_SWALLOW
    } pend_t;

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    logic               ctrl_expected_reg, ctrl_expected_next;
    logic               cont_flag_reg,     cont_flag_next;
    logic               data_mode_reg,     data_mode_next;
    pend_t              pend_reg,          pend_next;
    logic [COL_W-1:0]   col_start_reg,     col_start_next;
    logic [COL_W-1:0]   col_end_reg,       col_end_next;
    logic [PAGE_W-1:0]  page_start_reg,    page_start_next;
    logic [PAGE_W-1:0]  page_end_reg,      page_end_next;
    logic [COL_W-1:0]   cur_col_reg,       cur_col_next;
    logic [PAGE_W-1:0]  cur_page_reg,      cur_page_next;
    logic               disp_on_reg,       disp_on_next;
    logic               inverse_reg,       inverse_next;

    // Clear pass over the display RAM after reset
    logic               clr_active_reg;
    logic [RAM_AW-1:0]  clr_addr_reg;

    // Output register
    logic               m_valid_reg;
    logic               acked_reg;
    logic               written_reg;
    logic [COL_W-1:0]   wr_col_reg;
    logic [PAGE_W-1:0]  wr_page_reg;
    logic               disp_en_reg;
    logic               disp_inv_reg;

    logic               s_accept;
    logic               data_write;
    logic [RAM_AW-1:0]  cur_addr;
    logic               ram_we;
    logic [RAM_AW-1:0]  ram_waddr;
    logic [RAM_DW-1:0]  ram_wdata;

    assign s_ready  = !clr_active_reg && (!m_valid_reg || m_ready);
    assign s_accept = s_valid && s_ready;

    // Linear RAM address of the cursor, wrapped to the RAM depth
    assign cur_addr = RAM_AW'(cur_col_reg)
                    + RAM_AW'(RAM_AW'(cur_page_reg) * RAM_AW'(PANEL_COLUMNS));

    // ------------------------------------------------------------------
    // Event decode and next state
    // ------------------------------------------------------------------
    always_comb begin
        logic [COL_W-1:0]  col_inc;
        logic [PAGE_W-1:0] page_inc;
        logic              window_ok;

        ctrl_expected_next = ctrl_expected_reg;
        cont_flag_next     = cont_flag_reg;
        data_mode_next     = data_mode_reg;
        pend_next          = pend_reg;
        col_start_next     = col_start_reg;
        col_end_next       = col_end_reg;
        page_start_next    = page_start_reg;
        page_end_next      = page_end_reg;
        cur_col_next       = cur_col_reg;
        cur_page_next      = cur_page_reg;
        disp_on_next       = disp_on_reg;
        inverse_next       = inverse_reg;
        data_write         = 1'b0;

        col_inc   = cur_col_reg + COL_W'(1);
        page_inc  = cur_page_reg + PAGE_W'(1);
        window_ok = (col_end_reg >= col_start_reg) && (page_end_reg >= page_start_reg);

        if (s_opcode == OP_STOP) begin
            // Re-arm the control byte only; an awaited parameter stays awaited
            ctrl_expected_next = 1'b1;
        end else if (s_opcode == OP_WRITE) begin
            if (ctrl_expected_reg) begin
                cont_flag_next     = s_data_byte[CTRL_CONT_BIT];
                data_mode_next     = s_data_byte[CTRL_DATA_BIT];
                ctrl_expected_next = 1'b0;
            end else begin
                if (data_mode_reg) begin
                    // Skip the write entirely when the window is inverted
                    if (window_ok) begin
                        data_write = 1'b1;
                        if (col_inc > col_end_reg || col_inc == '0) begin
                            cur_col_next = col_start_reg;
                            if (page_inc > page_end_reg || page_inc == '0) begin
                                cur_page_next = page_start_reg;
                            end else begin
                                cur_page_next = page_inc;
                            end
                        end else begin
                            cur_col_next = col_inc;
                        end
                    end
                end else begin
                    case (pend_reg)
                        PEND_NONE: begin
                            case (s_data_byte)
                                CMD_DISPLAY_OFF: disp_on_next = 1'b0;
                                CMD_DISPLAY_ON:  disp_on_next = 1'b1;
                                CMD_NORMAL:      inverse_next = 1'b0;
                                CMD_INVERSE:     inverse_next = 1'b1;
                                CMD_COL_WINDOW:  pend_next    = PEND_COL_START;
                                CMD_PAGE_WINDOW: pend_next    = PEND_PAGE_START;
                                CMD_ADDR_MODE, CMD_CONTRAST, CMD_MUX_RATIO,
                                CMD_DISP_OFFSET, CMD_COM_PINS, CMD_CLOCK_DIV,
                                CMD_PRECHARGE, CMD_VCOM_DESEL, CMD_CHARGE_PUMP:
                                    pend_next = PEND_SWALLOW;
                                default: ;
                            endcase
                        end
                        PEND_COL_START: begin
                            col_start_next = (s_data_byte > 8'(MAX_COL))
                                           ? MAX_COL : s_data_byte[COL_W-1:0];
                            pend_next      = PEND_COL_END;
                        end
                        PEND_COL_END: begin
                            col_end_next  = (s_data_byte > 8'(MAX_COL))
                                          ? MAX_COL : s_data_byte[COL_W-1:0];
                            cur_col_next  = col_start_reg;
                            cur_page_next = page_start_reg;
                            pend_next     = PEND_NONE;
                        end
                        PEND_PAGE_START: begin
                            page_start_next = (s_data_byte > 8'(MAX_PAGE))
                                            ? MAX_PAGE : s_data_byte[PAGE_W-1:0];
                            pend_next       = PEND_PAGE_END;
                        end
                        PEND_PAGE_END: begin
                            page_end_next = (s_data_byte > 8'(MAX_PAGE))
                                          ? MAX_PAGE : s_data_byte[PAGE_W-1:0];
                            cur_col_next  = col_start_reg;
                            cur_page_next = page_start_reg;
                            pend_next     = PEND_NONE;
                        end
                        default: begin
                            // Swallowed parameter byte
                            pend_next = PEND_NONE;
                        end
                    endcase
                end
                if (cont_flag_reg) begin
                    ctrl_expected_next = 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Display RAM: clear pass first, then data transactions
    // ------------------------------------------------------------------
    assign ram_we    = clr_active_reg || (s_accept && data_write);
    assign ram_waddr = clr_active_reg ? clr_addr_reg : cur_addr;
    assign ram_wdata = clr_active_reg ? '0 : s_data_byte;

    ocdrw_ram #(
        .DATA_WIDTH (RAM_DW),
        .DEPTH      (RAM_DEPTH)
    ) u_display_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (cur_addr),
        .rd_data ()
    );

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_expected_reg <= 1'b1;
            cont_flag_reg     <= 1'b0;
            data_mode_reg     <= 1'b0;
            pend_reg          <= PEND_NONE;
            col_start_reg     <= '0;
            col_end_reg       <= MAX_COL;
            page_start_reg    <= '0;
            page_end_reg      <= MAX_PAGE;
            cur_col_reg       <= '0;
            cur_page_reg      <= '0;
            disp_on_reg       <= 1'b0;
            inverse_reg       <= 1'b0;
            clr_active_reg    <= 1'b1;
            clr_addr_reg      <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            // Advance the clear pass; drop it after the last entry
            if (clr_active_reg) begin
                clr_addr_reg <= clr_addr_reg + RAM_AW'(1);
                if (clr_addr_reg == RAM_AW'(RAM_DEPTH - 1)) begin
                    clr_active_reg <= 1'b0;
                end
            end

            if (s_accept) begin
                ctrl_expected_reg <= ctrl_expected_next;
                cont_flag_reg     <= cont_flag_next;
                data_mode_reg     <= data_mode_next;
                pend_reg          <= pend_next;
                col_start_reg     <= col_start_next;
                col_end_reg       <= col_end_next;
                page_start_reg    <= page_start_next;
                page_end_reg      <= page_end_next;
                cur_col_reg       <= cur_col_next;
                cur_page_reg      <= cur_page_next;
                disp_on_reg       <= disp_on_next;
                inverse_reg       <= inverse_next;
            end

            // Hold the result until taken; refill on every accepted transaction
            if (s_accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            acked_reg    <= (s_opcode == OP_WRITE);
            written_reg  <= data_write;
            wr_col_reg   <= data_write ? cur_col_reg  : '0;
            wr_page_reg  <= data_write ? cur_page_reg : '0;
            disp_en_reg  <= disp_on_next;
            disp_inv_reg <= inverse_next;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_acked            = acked_reg;
    assign m_ram_written      = written_reg;
    assign m_write_column     = wr_col_reg;
    assign m_write_page       = wr_page_reg;
    assign m_display_enabled  = disp_en_reg;
    assign m_display_inverted = disp_inv_reg;

endmodule
`default_nettype wire

// ----- dv/oled_writer_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// oled_writer_checker
// Watches both channels of the OLED command and display RAM writer, predicts
// the result of every bus event from its own copy of the controller state
// and compares each returned result field by field.
// ----------------------------------------------------------------------------
module oled_writer_checker
    import ocdrw_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [1:0]        s_opcode,
    input  logic [7:0]        s_data_byte,

    input  logic              m_valid,
    input  logic              m_ready,
    input  logic              m_acked,
    input  logic              m_ram_written,
    input  logic [COL_W-1:0]  m_write_column,
    input  logic [PAGE_W-1:0] m_write_page,
    input  logic              m_display_enabled,
    input  logic              m_display_inverted,

    output int                mismatch_count,
    output int                results_owed
);

    typedef enum logic [2:0] {
        AWAIT_NONE,
        AWAIT_COL_START,
        AWAIT_COL_END,
        AWAIT_PAGE_START,
        AWAIT_PAGE_END,
        AWAIT_SWALLOW
    } param_wait_t;

    typedef struct packed {
        logic              acked;
        logic              ram_written;
        logic [COL_W-1:0]  column;
        logic [PAGE_W-1:0] page;
        logic              enabled;
        logic              inverted;
    } panel_reply_t;

    // Controller state as seen from the bus
    logic              await_ctrl;
    logic              cont_latched;
    logic              data_latched;
    param_wait_t       param_wait;
    logic [COL_W-1:0]  col_lo, col_hi, cur_col;
    logic [PAGE_W-1:0] page_lo, page_hi, cur_page;
    logic              disp_on, inv_video;

    panel_reply_t      replies_owed_q[$];
    int                fail_tally;

    // Apply one bus event to the state and return the result it produces.
    function automatic panel_reply_t predict_bus_event(logic [1:0] op, logic [7:0] b);
        panel_reply_t      reply;
        logic [COL_W-1:0]  next_col;
        logic [PAGE_W-1:0] next_page;
        reply = '0;
        if (op == OP_STOP) begin
            await_ctrl = 1'b1;
        end else if (op == OP_WRITE) begin
            reply.acked = 1'b1;
            if (await_ctrl) begin
                cont_latched = b[CTRL_CONT_BIT];
                data_latched = b[CTRL_DATA_BIT];
                await_ctrl   = 1'b0;
            end else begin
                if (data_latched) begin
                    // an inverted window drops the byte and holds the cursor
                    if (col_hi >= col_lo && page_hi >= page_lo) begin
                        reply.ram_written = 1'b1;
                        reply.column      = cur_col;
                        reply.page        = cur_page;
                        next_col          = cur_col + 1'b1;
                        if (next_col > col_hi || next_col == '0) begin
                            cur_col   = col_lo;
                            next_page = cur_page + 1'b1;
                            if (next_page > page_hi || next_page == '0) begin
                                cur_page = page_lo;
                            end else begin
                                cur_page = next_page;
                            end
                        end else begin
                            cur_col = next_col;
                        end
                    end
                end else if (param_wait != AWAIT_NONE) begin
                    case (param_wait)
                        AWAIT_COL_START: begin
                            col_lo     = (b > 8'(MAX_COL)) ? MAX_COL : b[COL_W-1:0];
                            param_wait = AWAIT_COL_END;
                        end
                        AWAIT_COL_END: begin
                            col_hi     = (b > 8'(MAX_COL)) ? MAX_COL : b[COL_W-1:0];
                            param_wait = AWAIT_NONE;
                            cur_col    = col_lo;
                            cur_page   = page_lo;
                        end
                        AWAIT_PAGE_START: begin
                            page_lo    = (b > 8'(MAX_PAGE)) ? MAX_PAGE : b[PAGE_W-1:0];
                            param_wait = AWAIT_PAGE_END;
                        end
                        AWAIT_PAGE_END: begin
                            page_hi    = (b > 8'(MAX_PAGE)) ? MAX_PAGE : b[PAGE_W-1:0];
                            param_wait = AWAIT_NONE;
                            cur_col    = col_lo;
                            cur_page   = page_lo;
                        end
                        default: begin
                            param_wait = AWAIT_NONE;
                        end
                    endcase
                end else begin
                    case (b)
                        CMD_DISPLAY_OFF: disp_on   = 1'b0;
                        CMD_DISPLAY_ON:  disp_on   = 1'b1;
                        CMD_NORMAL:      inv_video = 1'b0;
                        CMD_INVERSE:     inv_video = 1'b1;
                        CMD_COL_WINDOW:  param_wait = AWAIT_COL_START;
                        CMD_PAGE_WINDOW: param_wait = AWAIT_PAGE_START;
                        CMD_ADDR_MODE, CMD_CONTRAST, CMD_MUX_RATIO, CMD_DISP_OFFSET,
                        CMD_COM_PINS, CMD_CLOCK_DIV, CMD_PRECHARGE, CMD_VCOM_DESEL,
                        CMD_CHARGE_PUMP: param_wait = AWAIT_SWALLOW;
                        default: ;
                    endcase
                end
                if (cont_latched) begin
                    await_ctrl = 1'b1;
                end
            end
        end
        reply.enabled  = disp_on;
        reply.inverted = inv_video;
        return reply;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_tally++;
        end
    endtask

    always @(posedge aclk) begin : watch
        panel_reply_t want;
        if (!aresetn) begin
            await_ctrl   = 1'b1;
            cont_latched = 1'b0;
            data_latched = 1'b0;
            param_wait   = AWAIT_NONE;
            col_lo       = '0;
            col_hi       = MAX_COL;
            page_lo      = '0;
            page_hi      = MAX_PAGE;
            cur_col      = '0;
            cur_page     = '0;
            disp_on      = 1'b0;
            inv_video    = 1'b0;
            replies_owed_q.delete();
        end else begin
            // compare before pushing: a result never belongs to this edge's input
            if (m_valid && m_ready) begin
                if (replies_owed_q.size() == 0) begin
                    $error("result transaction arrived with nothing outstanding");
                    fail_tally++;
                end else begin
                    want = replies_owed_q.pop_front();
                    check_field("acked", want.acked, m_acked);
                    check_field("ram_written", want.ram_written, m_ram_written);
                    check_field("write_column", want.column, m_write_column);
                    check_field("write_page", want.page, m_write_page);
                    check_field("display_enabled", want.enabled, m_display_enabled);
                    check_field("display_inverted", want.inverted, m_display_inverted);
                end
            end
            if (s_valid && s_ready) begin
                replies_owed_q.push_back(predict_bus_event(s_opcode, s_data_byte));
            end
        end
        mismatch_count <= fail_tally;
        results_owed   <= replies_owed_q.size();
    end

endmodule

// ----- dv/oled_command_and_display_ram_writer_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// oled_command_and_display_ram_writer_top_test
// Drives bus events into the OLED command and display RAM writer: a directed
// pass over commands, windows and corner cases, then random stop/control/
// payload bursts mixed with noise. A checker beside the block predicts and
// compares every result; this module only stimulates and gives the verdict.
// ----------------------------------------------------------------------------
module oled_command_and_display_ram_writer_top_test;
    import ocdrw_pkg::*;

    // Opcode 3 is unused; the block must treat it like a read
    localparam logic [1:0] OP_RESERVED = 2'd3;

    localparam int IDLE_PCT       = 30;
    localparam int ITEM_TARGET    = 950;
    localparam int CALM_FIRST     = 450;
    localparam int CALM_LAST      = 600;
    localparam int HOLD_AFTER     = 200;
    localparam int HOLD_CYCLES    = 150;
    // Covers the RAM clearing pass after reset plus the long receiver hold-off
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 16;

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    logic [1:0]        s_opcode    = OP_WRITE;
    logic [7:0]        s_data_byte = 8'h00;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    logic              m_acked;
    logic              m_ram_written;
    logic [COL_W-1:0]  m_write_column;
    logic [PAGE_W-1:0] m_write_page;
    logic              m_display_enabled;
    logic              m_display_inverted;

    int                mismatch_count;
    int                results_owed;
    logic              calm_stretch = 1'b0;
    int                items_sent   = 0;
    int                results_seen = 0;
    int                quiet_cycles = 0;
    logic [7:0]        burst_bytes[$];

    always #1 aclk = ~aclk;

    oled_command_and_display_ram_writer_top DUT (.*);

    oled_writer_checker scoreboard (.*);

    // Offer one transaction, idling at random first; return once it is taken.
    task automatic send_item(input logic [1:0] op, input logic [7:0] b);
        while (!calm_stretch && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_opcode    <= op;
        s_data_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // Build a control byte; the low six bits carry no meaning, so randomize them.
    function automatic logic [7:0] control_byte(logic cont, logic data_mode);
        logic [7:0] b;
        b                = 8'($urandom);
        b[CTRL_CONT_BIT] = cont;
        b[CTRL_DATA_BIT] = data_mode;
        return b;
    endfunction

    // Pick a window: mostly small and well formed, sometimes full width,
    // inverted, or out of the panel so that clamping kicks in.
    function automatic void window_bounds(input int last, output int lo, output int hi);
        case ($urandom_range(0, 9))
            7: begin
                lo = 0;
                hi = last;
            end
            8: begin
                lo = int'($urandom_range(1, last));
                hi = int'($urandom_range(0, lo - 1));
            end
            9: begin
                lo = int'($urandom_range(0, 255));
                hi = int'($urandom_range(0, 255));
            end
            default: begin
                lo = int'($urandom_range(0, last));
                hi = lo + int'($urandom_range(0, (last > 7) ? 7 : 2));
                if (hi > last) hi = last;
            end
        endcase
    endfunction

    // Append one command, with its parameter bytes, to the burst.
    function automatic void queue_command();
        int         lo, hi;
        logic [7:0] cmd;
        case ($urandom_range(0, 9))
            0: burst_bytes.push_back(CMD_DISPLAY_ON);
            1: burst_bytes.push_back(CMD_DISPLAY_OFF);
            2: burst_bytes.push_back(CMD_NORMAL);
            3: burst_bytes.push_back(CMD_INVERSE);
            4: begin
                window_bounds(int'(MAX_COL), lo, hi);
                burst_bytes.push_back(CMD_COL_WINDOW);
                burst_bytes.push_back(8'(lo));
                burst_bytes.push_back(8'(hi));
            end
            5: begin
                window_bounds(int'(MAX_PAGE), lo, hi);
                burst_bytes.push_back(CMD_PAGE_WINDOW);
                burst_bytes.push_back(8'(lo));
                burst_bytes.push_back(8'(hi));
            end
            6, 7: begin
                case ($urandom_range(0, 8))
                    0:       cmd = CMD_ADDR_MODE;
                    1:       cmd = CMD_CONTRAST;
                    2:       cmd = CMD_MUX_RATIO;
                    3:       cmd = CMD_DISP_OFFSET;
                    4:       cmd = CMD_COM_PINS;
                    5:       cmd = CMD_CLOCK_DIV;
                    6:       cmd = CMD_PRECHARGE;
                    7:       cmd = CMD_VCOM_DESEL;
                    default: cmd = CMD_CHARGE_PUMP;
                endcase
                burst_bytes.push_back(cmd);
                burst_bytes.push_back(8'($urandom));
            end
            8: burst_bytes.push_back(8'($urandom));
            // leave a window command without its parameters
            default: burst_bytes.push_back(CMD_COL_WINDOW);
        endcase
    endfunction

    // One well-formed bus transfer: stop, control byte, then a payload of data
    // or commands. With continuation set, a control byte precedes each
    // payload byte and may switch mode, so parameters also land as data.
    task automatic run_burst();
        logic cont, data_mode;
        int   n;
        send_item(OP_STOP, 8'($urandom));
        cont      = 1'($urandom_range(0, 1));
        data_mode = 1'($urandom_range(0, 1));
        burst_bytes.delete();
        if (data_mode) begin
            n = ($urandom_range(0, 9) == 0) ? int'($urandom_range(30, 70))
                                             : int'($urandom_range(1, 12));
            repeat (n) burst_bytes.push_back(8'($urandom));
        end else begin
            n = int'($urandom_range(1, 4));
            repeat (n) queue_command();
        end
        send_item(OP_WRITE, control_byte(cont, data_mode));
        foreach (burst_bytes[i]) begin
            if (i > 0 && cont) begin
                cont = ($urandom_range(0, 7) != 0);
                if ($urandom_range(0, 9) == 0) data_mode = ~data_mode;
                send_item(OP_WRITE, control_byte(cont, data_mode));
            end
            if ($urandom_range(0, 19) == 0) send_item(OP_READ, 8'($urandom));
            send_item(OP_WRITE, burst_bytes[i]);
        end
    endtask

    // Receiver: random back-pressure, none during the calm stretch, and one
    // long hold-off so the output register fills and the input stalls.
    initial begin : receiver
        logic held_off;
        held_off = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) results_seen++;
            if (!held_off && results_seen >= HOLD_AFTER) begin
                held_off = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= calm_stretch || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog: end the run if no transaction moves on either channel for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed pass. Reads and the unused opcode come first: no ack, no effect.
        send_item(OP_READ, 8'hFF);
        send_item(OP_RESERVED, 8'h00);
        send_item(OP_WRITE, control_byte(1'b0, 1'b0));
        send_item(OP_WRITE, CMD_DISPLAY_ON);
        send_item(OP_WRITE, CMD_INVERSE);
        send_item(OP_WRITE, CMD_COL_WINDOW);
        send_item(OP_WRITE, 8'hFF);           // start clamps to the last column
        send_item(OP_STOP, 8'h00);            // stop while the end byte is awaited
        send_item(OP_WRITE, control_byte(1'b0, 1'b0));
        send_item(OP_WRITE, 8'h00);           // still taken as the end: window inverted
        send_item(OP_STOP, 8'hFF);
        send_item(OP_WRITE, control_byte(1'b0, 1'b1));
        send_item(OP_WRITE, 8'hA5);           // inverted window: acked, nothing stored
        send_item(OP_STOP, 8'h00);
        send_item(OP_WRITE, control_byte(1'b0, 1'b0));
        send_item(OP_WRITE, CMD_COL_WINDOW);
        send_item(OP_WRITE, 8'd126);
        send_item(OP_WRITE, 8'hFF);
        send_item(OP_WRITE, CMD_PAGE_WINDOW);
        send_item(OP_WRITE, 8'd6);
        send_item(OP_WRITE, 8'h80);           // page end clamps to the last page
        send_item(OP_WRITE, CMD_CONTRAST);    // parameter left pending across the stop
        send_item(OP_STOP, 8'h00);
        send_item(OP_WRITE, control_byte(1'b1, 1'b1));
        send_item(OP_WRITE, 8'h00);           // data never consumes the pending parameter
        send_item(OP_WRITE, control_byte(1'b0, 1'b1));
        // walk the 2x2 window through both wraps
        repeat (5) send_item(OP_WRITE, 8'($urandom));
        send_item(OP_STOP, 8'h00);
        send_item(OP_WRITE, control_byte(1'b0, 1'b0));
        send_item(OP_WRITE, 8'h55);           // swallowed by the pending contrast
        send_item(OP_WRITE, CMD_NORMAL);
        send_item(OP_WRITE, CMD_DISPLAY_OFF);

        // Random pass: mostly well-formed bursts, the rest noise
        while (items_sent < ITEM_TARGET) begin
            calm_stretch <= (items_sent >= CALM_FIRST && items_sent < CALM_LAST);
            if ($urandom_range(99) < 85) begin
                run_burst();
            end else begin
                repeat ($urandom_range(1, 3)) send_item(2'($urandom_range(0, 3)), 8'($urandom));
            end
        end
        s_valid <= 1'b0;

        // Let the checker's count catch up with the last push, then drain
        @(posedge aclk);
        while (results_owed != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/ocdrw_pkg.sv
hdl/ocdrw_ram.sv
hdl/oled_command_and_display_ram_writer_top.sv
dv/oled_writer_checker.sv
dv/oled_command_and_display_ram_writer_top_test.sv
